### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aip_pkg.sv
// Shared types and constants of the ASCII integer parser.
package aip_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

  // Character classes handed from the classifier to the parser.
  typedef enum logic [2:0] {
    TK_TERM,
    TK_SPACE,
    TK_MINUS,
    TK_PLUS,
    TK_XCHAR,
    TK_DEC,
    TK_HEXL,
    TK_OTHER
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
  } token_t;

endpackage

### design/aip_front.sv
// Input side: classifies each incoming word into a character token.
module aip_front (
  input  logic            text_byte_valid_i,
  output logic            text_byte_ready_o,
  input  logic [7:0]      text_byte_i,
  output logic            tok_valid_o,
  input  logic            tok_full_i,
  output aip_pkg::token_t tok_o
);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoX   = 8'h78;

  assign text_byte_ready_o = !tok_full_i;
  assign tok_valid_o       = text_byte_valid_i && !tok_full_i;

  always_comb begin
    tok_o.kind  = aip_pkg::TK_OTHER;
    tok_o.digit = text_byte_i[3:0];
    if (text_byte_i == ChNul) begin
      tok_o.kind = aip_pkg::TK_TERM;
    end else if (text_byte_i inside {ChSpace, ChTab, ChLf, ChCr}) begin
      tok_o.kind = aip_pkg::TK_SPACE;
    end else if (text_byte_i == ChMinus) begin
      tok_o.kind = aip_pkg::TK_MINUS;
    end else if (text_byte_i == ChPlus) begin
      tok_o.kind = aip_pkg::TK_PLUS;
    end else if (text_byte_i inside {ChUpX, ChLoX}) begin
      tok_o.kind = aip_pkg::TK_XCHAR;
    end else if (text_byte_i inside {[ChZero:ChNine]}) begin
      tok_o.kind = aip_pkg::TK_DEC;
    end else if (text_byte_i inside {[ChUpA:ChUpF], [ChLoA:ChLoF]}) begin
      // letter a..f has low bits 1..6, add 9 for 10..15
      tok_o.kind  = aip_pkg::TK_HEXL;
      tok_o.digit = {1'b0, text_byte_i[2:0]} + 4'd9;
    end
  end

endmodule

### design/aip_fifo.sv
// Short token queue between the classifier and the parser.
module aip_fifo #(
  parameter int unsigned DEPTH = aip_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aip_pkg::token_t push_data_i,
  output logic            full_o,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output aip_pkg::token_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  aip_pkg::token_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o      = (count_q == CntW'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/aip_back.sv
// Parser side: runs the phase machine and accumulator, registers each result.
module aip_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  aip_pkg::token_t    tok_i,
  output logic               tok_pop_o,
  output logic               parsed_value_valid_o,
  input  logic               parsed_value_ready_i,
  output logic signed [31:0] parsed_value_o
);

  localparam logic [2:0] PhSkip = 3'd0;
  localparam logic [2:0] PhSign = 3'd1;
  localparam logic [2:0] PhZero = 3'd2;
  localparam logic [2:0] PhDec  = 3'd3;
  localparam logic [2:0] PhHex  = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic        neg_q, neg_d;
  logic        hex_q, hex_d;
  logic [31:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        is_term;
  logic [2:0]  eff_phase;
  logic [31:0] acc_dec;
  logic [31:0] acc_hex;
  logic        is_digit;

  assign is_term   = (tok_i.kind == aip_pkg::TK_TERM);
  // a terminator waits only while the result register is still occupied
  assign tok_pop_o = tok_valid_i && (!is_term || !out_valid_q || parsed_value_ready_i);

  assign parsed_value_valid_o = out_valid_q;
  assign parsed_value_o       = $signed(out_data_q);

  assign acc_dec  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, tok_i.digit};
  assign acc_hex  = {acc_q[27:0], tok_i.digit};
  assign is_digit = (tok_i.kind == aip_pkg::TK_DEC);

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    eff_phase   = phase_q;

    if (parsed_value_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (tok_pop_o) begin
      if (is_term) begin
        out_valid_d = 1'b1;
        out_data_d  = (!hex_q && neg_q) ? (~acc_q + 32'd1) : acc_q;
        phase_d     = PhSkip;
        neg_d       = 1'b0;
        hex_d       = 1'b0;
        acc_d       = '0;
      end else begin
        // leave skip on anything but blanks; a non-sign is handled as after sign
        if (phase_q == PhSkip) begin
          eff_phase = PhSkip;
          case (tok_i.kind)
            aip_pkg::TK_SPACE: eff_phase = PhSkip;
            aip_pkg::TK_MINUS: begin
              neg_d   = 1'b1;
              phase_d = PhSign;
            end
            aip_pkg::TK_PLUS:  phase_d = PhSign;
            default:           eff_phase = PhSign;
          endcase
        end
        case (eff_phase)
          PhSign: begin
            if (is_digit && tok_i.digit == 4'd0) begin
              phase_d = PhZero;
            end else if (is_digit) begin
              acc_d   = {28'd0, tok_i.digit};
              phase_d = PhDec;
            end else begin
              phase_d = PhDone;
            end
          end
          PhZero: begin
            if (tok_i.kind == aip_pkg::TK_XCHAR) begin
              hex_d   = 1'b1;
              phase_d = PhHex;
            end else if (is_digit) begin
              acc_d   = {28'd0, tok_i.digit};
              phase_d = PhDec;
            end else begin
              phase_d = PhDone;
            end
          end
          PhDec: begin
            if (is_digit) begin
              acc_d = acc_dec;
            end else begin
              phase_d = PhDone;
            end
          end
          PhHex: begin
            if (is_digit || tok_i.kind == aip_pkg::TK_HEXL) begin
              acc_d = acc_hex;
            end else begin
              phase_d = PhDone;
            end
          end
          default: begin
            // skip and done phases hold; unused codes behave as done
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSkip;
      neg_q       <= 1'b0;
      hex_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      hex_q       <= hex_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

### design/ascii_integer_parser.sv
// Top level of the ASCII integer parser: classifier, token queue and parser.
// Takes one character word per cycle while the queue has room, and gives one 32-bit
// value per zero terminator. A classifier tags each byte (blank, sign, x, digit and its
// value) into a FIFO_DEPTH-entry queue; the parser pops one token per cycle, unless a
// terminator waits on the result register, and folds it into the accumulator with
// one shift-add step. The result is registered and held on parsed_value_o until taken.
// A result still waiting at the output stalls only the next terminator; digits keep
// flowing, and input backs up only once the queue is full.
module ascii_integer_parser #(
  parameter int unsigned FIFO_DEPTH = aip_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               text_byte_valid_i,
  output logic               text_byte_ready_o,
  input  logic [7:0]         text_byte_i,
  output logic               parsed_value_valid_o,
  input  logic               parsed_value_ready_i,
  output logic signed [31:0] parsed_value_o
);

  aip_pkg::token_t push_tok;
  aip_pkg::token_t pop_tok;
  logic            push;
  logic            full;
  logic            pop_valid;
  logic            pop;

  aip_front u_front (
    .text_byte_valid_i (text_byte_valid_i),
    .text_byte_ready_o (text_byte_ready_o),
    .text_byte_i       (text_byte_i),
    .tok_valid_o       (push),
    .tok_full_i        (full),
    .tok_o             (push_tok)
  );

  aip_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tok),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_tok)
  );

  aip_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .tok_valid_i          (pop_valid),
    .tok_i                (pop_tok),
    .tok_pop_o            (pop),
    .parsed_value_valid_o (parsed_value_valid_o),
    .parsed_value_ready_i (parsed_value_ready_i),
    .parsed_value_o       (parsed_value_o)
  );

endmodule

### design/aip_checker.sv
// Port-level checker for the ASCII integer parser, bound to the top level.
`include "assert_macros.svh"

module aip_checker #(
  parameter int unsigned FIFO_DEPTH = aip_pkg::FIFO_DEPTH_DEFAULT
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               text_byte_valid_i,
  input logic               text_byte_ready_o,
  input logic [7:0]         text_byte_i,
  input logic               parsed_value_valid_o,
  input logic               parsed_value_ready_i,
  input logic signed [31:0] parsed_value_o
);

  localparam int unsigned PendW = $clog2(FIFO_DEPTH + 3);

  // terminators accepted whose results are not yet delivered
  logic [PendW-1:0] pend_q, pend_d;
  logic             term_acc;
  logic             out_acc;

  assign term_acc = text_byte_valid_i && text_byte_ready_o && (text_byte_i == 8'h00);
  assign out_acc  = parsed_value_valid_o && parsed_value_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (term_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (!term_acc && out_acc && pend_q != '0) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `AIP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, parsed_value_valid_o && !parsed_value_ready_i, parsed_value_valid_o, "result dropped before it was taken")
  `AIP_ASSERT_NXT(a_out_stable, clk_i, rst_ni, parsed_value_valid_o && !parsed_value_ready_i, $stable(parsed_value_o), "stalled result changed")
  `AIP_ASSERT_IMP(a_no_invent, clk_i, rst_ni, parsed_value_valid_o, pend_q != '0, "result without a terminator")
  `AIP_ASSERT_IMP(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q <= PendW'(FIFO_DEPTH + 1), "more terminators in flight than the queue holds")

endmodule

bind ascii_integer_parser aip_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_aip_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .text_byte_valid_i    (text_byte_valid_i),
  .text_byte_ready_o    (text_byte_ready_o),
  .text_byte_i          (text_byte_i),
  .parsed_value_valid_o (parsed_value_valid_o),
  .parsed_value_ready_i (parsed_value_ready_i),
  .parsed_value_o       (parsed_value_o)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the ASCII integer parser: directed strings, then random ones.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 400;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [4:0] NOT_HEX  = 5'd16;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_SIGNED,
    PH_LEAD_ZERO,
    PH_DECIMAL,
    PH_HEX,
    PH_STOP
  } phase_e;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               text_byte_valid_i = 1'b0;
  logic               text_byte_ready_o;
  logic [7:0]         text_byte_i = CH_NUL;
  logic               parsed_value_valid_o;
  logic               parsed_value_ready_i = 1'b0;
  logic signed [31:0] parsed_value_o;

  ascii_integer_parser dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .text_byte_valid_i    (text_byte_valid_i),
    .text_byte_ready_o    (text_byte_ready_o),
    .text_byte_i          (text_byte_i),
    .parsed_value_valid_o (parsed_value_valid_o),
    .parsed_value_ready_i (parsed_value_ready_i),
    .parsed_value_o       (parsed_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Parser state mirrored by the testbench.
  phase_e      parse_phase = PH_BLANK;
  logic        is_negative = 1'b0;
  logic        is_hex = 1'b0;
  logic [31:0] running_value = '0;
  logic [31:0] expected_values[$];

  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (is_digit(c)) return 5'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
    if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
    return NOT_HEX;
  endfunction

  // Advance the mirrored state by one character; a terminator queues a value.
  function automatic void fold_char(input logic [7:0] c);
    logic [31:0] v;
    logic [4:0]  h;
    if (c == CH_NUL) begin
      v = running_value;
      if (!is_hex && is_negative) v = -v;
      expected_values.push_back(v);
      parse_phase = PH_BLANK;
      is_negative = 1'b0;
      is_hex = 1'b0;
      running_value = '0;
      return;
    end
    if (parse_phase == PH_BLANK) begin
      if (is_blank(c)) return;
      if (c == CH_MINUS) begin
        is_negative = 1'b1;
        parse_phase = PH_SIGNED;
        return;
      end
      if (c == CH_PLUS) begin
        parse_phase = PH_SIGNED;
        return;
      end
      parse_phase = PH_SIGNED;
    end
    case (parse_phase)
      PH_SIGNED: begin
        if (c == CH_ZERO) parse_phase = PH_LEAD_ZERO;
        else if (is_digit(c)) begin
          running_value = 32'(c - CH_ZERO);
          parse_phase = PH_DECIMAL;
        end else parse_phase = PH_STOP;
      end
      PH_LEAD_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          is_hex = 1'b1;
          parse_phase = PH_HEX;
        end else if (is_digit(c)) begin
          running_value = 32'(c - CH_ZERO);
          parse_phase = PH_DECIMAL;
        end else parse_phase = PH_STOP;
      end
      PH_DECIMAL: begin
        if (is_digit(c)) running_value = running_value * 32'd10 + 32'(c - CH_ZERO);
        else parse_phase = PH_STOP;
      end
      PH_HEX: begin
        h = hex_digit(c);
        if (h != NOT_HEX) running_value = {running_value[27:0], h[3:0]};
        else parse_phase = PH_STOP;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0d (0x%08h), expected %0d (0x%08h)", $realtime, what,
             $signed(got), got, $signed(want), want);
    err_count++;
  endtask

  // Send one word; gaps fall between bursts of random length.
  task automatic send_char(input logic [7:0] c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        text_byte_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    text_byte_valid_i <= 1'b1;
    text_byte_i <= c;
    do @(posedge clk_i); while (!text_byte_ready_o);
    fold_char(c);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]));
  endtask

  // Blanks of every kind, a plus sign, a leading zero before decimal, junk after digits.
  task automatic test_blank_and_sign();
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    send_text("+07");
    send_char(8'h80);
    send_text("9");
    send_char(CH_NUL);
  endtask

  // Hex with a sign that is dropped, mixed case digits, and a bare prefix.
  task automatic test_hex_prefix();
    send_text("-0xfF");
    send_char(CH_NUL);
    send_text("0X");
    send_char(8'hFF);
    send_char(CH_NUL);
  endtask

  // A lone sign gives zero; a decimal that wraps past 2^32 and is then negated.
  task automatic test_empty_and_wrap();
    send_text("-");
    send_char(CH_NUL);
    send_text("-4294967297");
    send_char(CH_NUL);
  endtask

  task automatic test_random_strings();
    int unsigned kind;
    int unsigned n;
    int unsigned h;
    while (words_sent < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // noise: arbitrary nonzero words, then a terminator
        n = $urandom_range(0, 6);
        repeat (n) send_char(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 3))
            0: send_char(CH_SPACE);
            1: send_char(CH_TAB);
            2: send_char(CH_CR);
            default: send_char(CH_LF);
          endcase
        end
        case ($urandom_range(0, 2))
          1: send_char(CH_MINUS);
          2: send_char(CH_PLUS);
          default: ;
        endcase
        if (kind < 45) begin
          send_char(CH_ZERO);
          send_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
          n = $urandom_range(0, 10);
          repeat (n) begin
            h = $urandom_range(0, 15);
            if (h < 10) send_char(8'(CH_ZERO + h));
            else send_char(8'(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + h - 10));
          end
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 4) == 0) begin
          send_char(8'($urandom_range(1, 255)));
          repeat ($urandom_range(0, 3)) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
      end
      send_char(CH_NUL);
    end
  endtask

  // Result side: a stall pattern whose mode changes now and then.
  initial begin : sink_pattern
    int unsigned mode;
    int unsigned left;
    int unsigned hold;
    logic        open;
    hold = 0;
    open = 1'b1;
    forever begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(40, 150);
      while (left > 0) begin
        @(posedge clk_i);
        case (mode)
          0: parsed_value_ready_i <= 1'b1;
          1: parsed_value_ready_i <= 1'($urandom_range(0, 1));
          default: begin
            if (hold == 0) begin
              open = !open;
              hold = open ? $urandom_range(1, 4) : $urandom_range(5, 30);
            end
            hold--;
            parsed_value_ready_i <= open;
          end
        endcase
        left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && parsed_value_valid_o && parsed_value_ready_i) begin
      if (expected_values.size() == 0) begin
        report_mismatch("result with nothing expected", parsed_value_o, '0);
      end else if (parsed_value_o !== expected_values[0]) begin
        report_mismatch("parsed_value", parsed_value_o, expected_values[0]);
        void'(expected_values.pop_front());
      end else begin
        void'(expected_values.pop_front());
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (text_byte_valid_i && text_byte_ready_o) ||
        (parsed_value_valid_o && parsed_value_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_tests
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_blank_and_sign();
    test_hex_prefix();
    test_empty_and_wrap();
    test_random_strings();
    text_byte_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && expected_values.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
